// File: rtl/core/fnss_pkg.sv
// ----------------------------------------------------------------------------
// fnss_pkg: shared types and constants of the four-neighbour stencil sum
// Sizes of the line store, field widths, request and register codes, the
// item carried along the adder chain and the size clamps.
// ----------------------------------------------------------------------------
package fnss_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLN_W = $clog2(MAX_COLS + 1);
  localparam int ROWN_W = $clog2(MAX_ROWS + 1);

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int DATA_W    = 16;
  localparam int SUM_W     = 18;
  localparam int TERMS     = 3;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic REQ_ELEMENT = 1'b0;
  localparam logic REQ_DRAIN   = 1'b1;

  // Partial sum plus the terms still to be added; term 0 is added next
  typedef struct packed {
    logic signed [SUM_W-1:0]        acc;
    logic [TERMS-1:0][DATA_W-1:0]   term;
    logic [TERMS-1:0]               term_en;
    logic                           last;
  } cell_data_t;

  function automatic logic [ROWN_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [ROWN_W-1:0] res;
    if (v == '0) begin
      res = ROWN_W'(1);
    end else if (32'(v) > 32'(MAX_ROWS)) begin
      res = ROWN_W'(MAX_ROWS);
    end else begin
      res = ROWN_W'(v);
    end
    return res;
  endfunction

  function automatic logic [COLN_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [COLN_W-1:0] res;
    if (v == '0) begin
      res = COLN_W'(1);
    end else if (32'(v) > 32'(MAX_COLS)) begin
      res = COLN_W'(MAX_COLS);
    end else begin
      res = COLN_W'(v);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/fnss_ram.sv
// ----------------------------------------------------------------------------
// fnss_ram: generic RAM, one write port and two registered read ports
// Read-first: a read of the address written in the same cycle returns the
// old contents. Read data holds while read enable is low.
// ----------------------------------------------------------------------------
module fnss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: rtl/core/fnss_cell.sv
// ----------------------------------------------------------------------------
// fnss_cell: one adder cell of the stencil chain
// Adds the leading term to the partial sum, shifts the remaining terms down
// and hands the item to the next cell, with valid/ready stalling.
// ----------------------------------------------------------------------------
module fnss_cell
  import fnss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    data_nxt.acc = up_data.term_en[0]
                 ? up_data.acc + {{(SUM_W-DATA_W){up_data.term[0][DATA_W-1]}},
                                  up_data.term[0]}
                 : up_data.acc;
    for (int i = 0; i < TERMS - 1; i++) begin
      data_nxt.term[i]    = up_data.term[i+1];
      data_nxt.term_en[i] = up_data.term_en[i+1];
    end
    data_nxt.term[TERMS-1]    = '0;
    data_nxt.term_en[TERMS-1] = 1'b0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/core/fnss_front.sv
// ----------------------------------------------------------------------------
// fnss_front: raster tracking, line store and neighbour fetch
// Keeps the matrix position, the pending final row and the two line store
// banks, issues the neighbour reads of each item and presents the fetched
// terms to the adder chain. Clears the line store after reset.
// ----------------------------------------------------------------------------
module fnss_front
  import fnss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output cell_data_t               dn_data
);

  // configuration
  logic [CFG_W-1:0]  row_count_r;
  logic [CFG_W-1:0]  col_count_r;

  // raster and pending bookkeeping
  logic [ROW_W-1:0]  row_pos_r,   row_pos_nxt;
  logic [COL_W-1:0]  col_pos_r,   col_pos_nxt;
  logic [COLN_W-1:0] pending_r,   pending_nxt;
  logic [COLN_W-1:0] pend_cols_r, pend_cols_nxt;
  logic              frame_bank_r, frame_bank_nxt;
  logic              pend_bank_r,  pend_bank_nxt;
  logic              pend_north_r, pend_north_nxt;

  // clearing pass
  logic              clear_r;
  logic [COL_W-1:0]  clear_addr_r;

  // fetch stage
  logic                     s1_valid_r;
  logic signed [DATA_W-1:0] s1_base_r;
  logic [TERMS-1:0]         s1_en_r;
  logic                     s1_last_r;
  logic                     s1_cb_r;

  logic [ROWN_W-1:0] rows_n;
  logic [COLN_W-1:0] cols_n;
  logic              restart;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic              pend_ok;
  logic [COL_W-1:0]  p;
  logic              is_drain;
  logic              accept;
  logic              elem_acc;
  logic              use_elem;
  logic              release_now;
  logic              emit;
  logic              wbank;
  logic [COL_W-1:0]  pos;
  logic [COLN_W-1:0] lim;
  logic              cb;
  logic [TERMS-1:0]  en;
  logic [COL_W-1:0]  wa;
  logic [COL_W-1:0]  ea;
  logic [COLN_W-1:0] c_inc;
  logic [ROWN_W-1:0] r_inc;
  logic              s1_load;

  logic [DATA_W-1:0] rd_a [2];
  logic [DATA_W-1:0] rd_b [2];

  always_comb begin
    rows_n   = clamp_rows(row_count_r);
    cols_n   = clamp_cols(col_count_r);
    restart  = (ROWN_W'(row_pos_r) >= rows_n) || (COLN_W'(col_pos_r) >= cols_n);
    r        = restart ? '0 : row_pos_r;
    c        = restart ? '0 : col_pos_r;
    pend_ok  = (pending_r != '0) && (pending_r <= pend_cols_r);
    p        = COL_W'(pend_cols_r - pending_r);
    is_drain = (in_req_type == REQ_DRAIN);
    accept   = in_valid && in_ready;
    elem_acc = accept && !is_drain;
    use_elem = !is_drain && (r != '0);
    release_now = accept && pend_ok && (is_drain || (r == '0));
    emit     = release_now || (elem_acc && (r != '0));
    wbank    = frame_bank_r ^ r[0];

    // a row result looks at the stream; a release looks at the pending row
    pos = use_elem ? c : p;
    lim = use_elem ? cols_n : pend_cols_r;
    cb  = use_elem ? wbank : ~pend_bank_r;
    en[0] = use_elem ? (32'(r) >= 32'd2) : pend_north_r;
    en[1] = (pos != '0);
    en[2] = (COLN_W'(pos) + COLN_W'(1)) < lim;
    wa  = pos - COL_W'(1);
    ea  = pos + COL_W'(1);
  end

  always_comb begin
    row_pos_nxt    = row_pos_r;
    col_pos_nxt    = col_pos_r;
    pending_nxt    = pending_r;
    pend_cols_nxt  = pend_cols_r;
    frame_bank_nxt = frame_bank_r;
    pend_bank_nxt  = pend_bank_r;
    pend_north_nxt = pend_north_r;
    c_inc          = COLN_W'(c) + COLN_W'(1);
    r_inc          = ROWN_W'(r) + ROWN_W'(1);

    if (accept && is_drain) begin
      pending_nxt = pend_ok ? pending_r - COLN_W'(1) : '0;
    end

    if (elem_acc) begin
      if (r != '0) begin
        pending_nxt = '0;
      end else if (pend_ok) begin
        pending_nxt = pending_r - COLN_W'(1);
      end

      if (c_inc >= cols_n) begin
        col_pos_nxt = '0;
        if (r_inc >= rows_n) begin
          // frame complete: its last row waits for release
          row_pos_nxt    = '0;
          pending_nxt    = cols_n;
          pend_cols_nxt  = cols_n;
          pend_bank_nxt  = wbank;
          pend_north_nxt = (32'(rows_n) >= 32'd2);
          frame_bank_nxt = ~wbank;
        end else begin
          row_pos_nxt = ROW_W'(r_inc);
        end
      end else begin
        col_pos_nxt = COL_W'(c_inc);
        row_pos_nxt = r;
      end
    end
  end

  assign in_ready = !clear_r && (!s1_valid_r || dn_ready);
  assign s1_load  = !s1_valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count_r <= cfg_wdata;
        REG_COL_COUNT: col_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      pending_r    <= '0;
      pend_cols_r  <= '0;
      frame_bank_r <= 1'b0;
      pend_bank_r  <= 1'b0;
      pend_north_r <= 1'b0;
      clear_r      <= 1'b1;
      clear_addr_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      row_pos_r    <= row_pos_nxt;
      col_pos_r    <= col_pos_nxt;
      pending_r    <= pending_nxt;
      pend_cols_r  <= pend_cols_nxt;
      frame_bank_r <= frame_bank_nxt;
      pend_bank_r  <= pend_bank_nxt;
      pend_north_r <= pend_north_nxt;
      if (clear_r) begin
        clear_addr_r <= clear_addr_r + COL_W'(1);
        if (clear_addr_r == COL_W'(MAX_COLS - 1)) begin
          clear_r <= 1'b0;
        end
      end
      if (s1_load) begin
        s1_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s1_load) begin
      s1_base_r <= use_elem ? in_element_value : '0;
      s1_en_r   <= en;
      s1_last_r <= release_now && (pending_r == COLN_W'(1));
      s1_cb_r   <= cb;
    end
  end

  // one RAM per bank; the centre bank reads on port A, the side bank reads
  // west on port A and east on port B
  for (genvar k = 0; k < 2; k++) begin : g_bank
    logic              we_k;
    logic [COL_W-1:0]  waddr_k;
    logic [DATA_W-1:0] wdata_k;
    logic [COL_W-1:0]  raddr_a_k;

    assign we_k      = clear_r || (elem_acc && (wbank == 1'(k)));
    assign waddr_k   = clear_r ? clear_addr_r : c;
    assign wdata_k   = clear_r ? '0 : in_element_value;
    assign raddr_a_k = (cb == 1'(k)) ? pos : wa;

    fnss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COLS)
    ) u_ram (
      .clk     (clk),
      .we      (we_k),
      .waddr   (waddr_k),
      .wdata   (wdata_k),
      .re      (accept),
      .raddr_a (raddr_a_k),
      .raddr_b (ea),
      .rdata_a (rd_a[k]),
      .rdata_b (rd_b[k])
    );
  end

  always_comb begin
    dn_data.acc     = {{(SUM_W-DATA_W){s1_base_r[DATA_W-1]}}, s1_base_r};
    dn_data.term[0] = rd_a[s1_cb_r];
    dn_data.term[1] = rd_a[~s1_cb_r];
    dn_data.term[2] = rd_b[~s1_cb_r];
    dn_data.term_en = s1_en_r;
    dn_data.last    = s1_last_r;
  end

  assign dn_valid = s1_valid_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_ready)
    else $error("item accepted during line store clear");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= pend_cols_r)
    else $error("pending count above pending row width");

  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != '0) |-> (frame_bank_r != pend_bank_r))
    else $error("new frame shares the bank of the pending row");

  a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_drain && (pending_r == '0)) |=> !s1_valid_r)
    else $error("drain with nothing pending produced an item");

endmodule

// File: rtl/core/four_neighbour_stencil_sum_core.sv
// ----------------------------------------------------------------------------
// four_neighbour_stencil_sum_core: streaming four-neighbour sum, zero edges
// Input items are matrix elements in raster order or drain ticks; each
// result item is the sum of the north, south, west and east neighbours of
// one position, with positions outside the matrix counting as zero.
//
// Channels: in_* and out_* are valid/ready; cfg_* writes row_count (index 0)
// and col_count (index 1). The user must write them only while the block is
// idle; the block itself does not enforce it. Results of row r-1 come out
// while row r streams in, one per element. The last row of a frame waits until
// the next frame's first row or drain ticks release it, one item each;
// last_of_frame marks the final position. Throughput: one item per cycle
// when the output does not stall, set by one access of each line store bank
// port per item. Pipeline: fetch stage plus three adder cells.
// Reset: a clearing pass writes zero over all MAX_COLS (1024) line store
// addresses with in_ready low; configuration writes are taken meanwhile.
// Stall: with out_ready low the chain holds its items and in_ready falls
// once the fetch stage and all three cells are full.
// ----------------------------------------------------------------------------
module four_neighbour_stencil_sum_core
  import fnss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  out_neighbour_sum,
  output logic                     out_last_of_frame
);

  logic [TERMS:0] chain_valid;
  logic [TERMS:0] chain_ready;
  cell_data_t     chain_data [TERMS+1];

  fnss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_element_value (in_element_value),
    .dn_valid         (chain_valid[0]),
    .dn_ready         (chain_ready[0]),
    .dn_data          (chain_data[0])
  );

  // north, west, east added in turn
  for (genvar i = 0; i < TERMS; i++) begin : g_cell
    fnss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  assign chain_ready[TERMS] = out_ready;
  assign out_valid          = chain_valid[TERMS];
  assign out_neighbour_sum  = chain_data[TERMS].acc;
  assign out_last_of_frame  = chain_data[TERMS].last;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Four-neighbour stencil sum: self-checking testbench
// Streams raster elements and drain ticks through the core with random
// handshake gaps. A scoreboard class models the two-bank line store and the
// pending last row, so it knows each expected neighbour sum and last flag.
// Each result is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import fnss_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 16;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } sum_item_t;

  class neighbour_sum_tracker;
    logic signed [DATA_W-1:0] line_mem [2*MAX_COLS];
    int row_pos, col_pos, pending, frame_bank, pend_bank, pend_cols;
    bit pend_north;
    logic [CFG_W-1:0] rows_reg, cols_reg;
    sum_item_t sums_due[$];
    int mismatches;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      row_pos = 0;
      col_pos = 0;
      pending = 0;
      frame_bank = 0;
      pend_bank = 0;
      pend_cols = 0;
      pend_north = 0;
      rows_reg = ROW_COUNT_RST;
      cols_reg = COL_COUNT_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_ROW_COUNT) rows_reg = val;
      else cols_reg = val;
    endfunction

    function int span(logic [CFG_W-1:0] val, int top);
      if (val == 0) return 1;
      if (int'(val) > top) return top;
      return int'(val);
    endfunction

    function int stored_at(int bank, int col);
      return int'(line_mem[(bank & 1) * MAX_COLS + (col % MAX_COLS)]);
    endfunction

    function void push_sum(int sum, bit last);
      sum_item_t e;
      e.sum = sum[SUM_W-1:0];
      e.last = last;
      sums_due.push_back(e);
    endfunction

    // next result of the held last row, in column order
    function void release_one();
      int p, sum;
      p = pend_cols - pending;
      sum = 0;
      if (pend_north) sum += stored_at(pend_bank ^ 1, p);
      if (p > 0) sum += stored_at(pend_bank, p - 1);
      if (p + 1 < pend_cols) sum += stored_at(pend_bank, p + 1);
      push_sum(sum, pending == 1);
      pending--;
    endfunction

    function void take_item(logic req, logic signed [DATA_W-1:0] v);
      int rows_n, cols_n, r, c, bank, above, sum, val;
      rows_n = span(rows_reg, MAX_ROWS);
      cols_n = span(cols_reg, MAX_COLS);
      val = int'(v);
      if (req == REQ_DRAIN) begin
        if (pending == 0 || pending > pend_cols) pending = 0;
        else release_one();
        return;
      end
      r = row_pos;
      c = col_pos;
      // position outside a shrunken matrix starts a new frame
      if (r >= rows_n || c >= cols_n) begin
        r = 0;
        c = 0;
      end
      if (r >= 1) begin
        sum = val;
        above = frame_bank ^ ((r - 1) & 1);
        pending = 0;
        if (r >= 2) sum += stored_at(above ^ 1, c);
        if (c > 0) sum += stored_at(above, c - 1);
        if (c + 1 < cols_n) sum += stored_at(above, c + 1);
        push_sum(sum, 1'b0);
      end else if (pending != 0 && pending <= pend_cols) begin
        release_one();
      end
      bank = frame_bank ^ (r & 1);
      line_mem[bank * MAX_COLS + c] = v;
      c++;
      if (c >= cols_n) begin
        c = 0;
        r++;
        if (r >= rows_n) begin
          pending = cols_n;
          pend_cols = cols_n;
          pend_bank = bank;
          pend_north = (rows_n >= 2);
          frame_bank = bank ^ 1;
          r = 0;
        end
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void match_result(logic signed [SUM_W-1:0] sum, logic last);
      sum_item_t e;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result: sum %0d last %0b", $time, sum, last);
        mismatches++;
        return;
      end
      e = sums_due.pop_front();
      if (sum !== e.sum) begin
        $display("%0t: neighbour_sum mismatch: expected %0d, actual %0d", $time, e.sum, sum);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_frame mismatch: expected %0b, actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_req_type;
  logic signed [DATA_W-1:0] in_element_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [SUM_W-1:0]  out_neighbour_sum;
  logic                     out_last_of_frame;

  neighbour_sum_tracker tracker = new();
  int  gap_pct = 0;
  bit  calm = 0;
  int  cycles = 0;

  four_neighbour_stencil_sum_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_neighbour_sum (out_neighbour_sum),
    .out_last_of_frame (out_last_of_frame)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off to back up the pipeline
  initial begin
    int taken, hold_left, stall_pct, tick;
    bit held_off;
    taken = 0;
    hold_left = 0;
    stall_pct = 0;
    tick = 0;
    held_off = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.match_result(out_neighbour_sum, out_last_of_frame);
        taken++;
      end
      tick++;
      if (tick % 128 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_off && taken >= 120) begin
        held_off = 1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic req, input logic signed [DATA_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_element_value <= v;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(req, v);
  endtask

  // hold until every result is out and the chain has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic resize(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                        input bit do_rows, input bit do_cols);
    settle();
    if (do_rows) write_reg(REG_ROW_COUNT, rows);
    if (do_cols) write_reg(REG_COL_COUNT, cols);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_rows();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(MAX_ROWS);
      3: return CFG_W'($urandom_range(MAX_ROWS + 1, 2047));
      default: return CFG_W'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_cols();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(1);
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    int counted, len, n, sel;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_ELEMENT;
    in_element_value = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2 x 3 frame of extremes, then release the held row by drain and element
    resize(11'd2, 11'd3, 1'b1, 1'b1);
    offer(REQ_ELEMENT, 16'sh7fff);
    offer(REQ_ELEMENT, 16'sh8000);
    offer(REQ_ELEMENT, 16'sh7fff);
    offer(REQ_ELEMENT, 16'sh8000);
    offer(REQ_ELEMENT, 16'sh0000);
    offer(REQ_ELEMENT, 16'shffff);
    offer(REQ_DRAIN, 16'sh5a5a);
    offer(REQ_ELEMENT, 16'sh1234);
    offer(REQ_DRAIN, 16'sha5a5);
    offer(REQ_DRAIN, 16'sh0000);

    // zero sizes act as 1 x 1; moves a mid-frame position out of range
    resize('0, '0, 1'b1, 1'b1);
    offer(REQ_ELEMENT, 16'sh4000);
    offer(REQ_ELEMENT, 16'shc000);
    offer(REQ_DRAIN, 16'shffff);

    // frame ends while older results are still held
    resize(11'd1, 11'd3, 1'b1, 1'b1);
    offer(REQ_ELEMENT, 16'sh7fff);
    offer(REQ_ELEMENT, 16'sh0001);
    offer(REQ_ELEMENT, 16'sh8000);
    resize(11'd1, 11'd1, 1'b0, 1'b1);
    offer(REQ_ELEMENT, 16'sh0101);
    offer(REQ_DRAIN, 16'sh0000);
    offer(REQ_DRAIN, 16'sh0000);

    // held row dropped when row 1 of the next frame arrives
    resize(11'd2, 11'd2, 1'b1, 1'b1);
    offer(REQ_ELEMENT, 16'sh0003);
    offer(REQ_ELEMENT, 16'sh0005);
    offer(REQ_ELEMENT, 16'sh0007);
    offer(REQ_ELEMENT, 16'sh000b);
    resize(11'd2, 11'd1, 1'b0, 1'b1);
    offer(REQ_ELEMENT, 16'sh0011);
    offer(REQ_ELEMENT, 16'sh0013);

    counted = 0;
    while (counted < 880) begin
      sel = $urandom_range(1, 3);
      resize(pick_rows(), pick_cols(), sel[0], sel[1]);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      len = $urandom_range(10, 60);
      repeat (len) begin
        if ($urandom_range(0, 99) < (tracker.pending != 0 ? 20 : 3)) begin
          if (tracker.pending != 0) counted++;
          offer(REQ_DRAIN, DATA_W'($urandom));
        end else begin
          counted++;
          offer(REQ_ELEMENT, pick_value());
        end
      end
      // flush the held row, sometimes with one drain too many
      if ($urandom_range(0, 1) == 1) begin
        n = tracker.pending + $urandom_range(0, 1);
        counted += tracker.pending;
        repeat (n) offer(REQ_DRAIN, DATA_W'($urandom));
      end
    end

    // two wide rows at full rate, the last one released entirely by drains
    settle();
    calm = 1;
    resize(11'd2, 11'd48, 1'b1, 1'b1);
    repeat (96) offer(REQ_ELEMENT, pick_value());
    repeat (49) offer(REQ_DRAIN, DATA_W'($urandom));

    settle();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
